@@ rtl/bkrf_pkg.sv @@
// shared types and constants of the button keyboard report framer
package bkrf_pkg;

	localparam int FRAME_LEN  = 14;
	localparam int SLOT_COUNT = 6;
	localparam int LEVEL_COUNT = 7;
	localparam int ADDR_W     = 2;

	localparam logic [ADDR_W-1:0] REG_DEVICE_ADDRESS = 2'd0;

	localparam logic [7:0] SYNC0     = 8'h57;
	localparam logic [7:0] SYNC1     = 8'hAB;
	localparam logic [7:0] CMD_BYTE  = 8'h02;
	localparam logic [7:0] LEN_BYTE  = 8'h08;
	localparam logic [7:0] PAD_BYTE  = 8'h00;

	localparam logic [7:0] CODE_LEFT   = 8'h50;
	localparam logic [7:0] CODE_DOWN   = 8'h51;
	localparam logic [7:0] CODE_UP     = 8'h52;
	localparam logic [7:0] CODE_RIGHT  = 8'h4F;
	localparam logic [7:0] CODE_ENTER  = 8'h28;
	localparam logic [7:0] CODE_ESCAPE = 8'h58;
	localparam logic [7:0] CODE_SPACE  = 8'h2C;
	localparam logic [7:0] CODE_NONE   = 8'h00;

	localparam int L_LEFT   = 0;
	localparam int L_DOWN   = 1;
	localparam int L_UP     = 2;
	localparam int L_RIGHT  = 3;
	localparam int L_ENTER  = 4;
	localparam int L_ESCAPE = 5;
	localparam int L_SPACE  = 6;

	typedef logic [7:0] byte_t;
	typedef byte_t [SLOT_COUNT-1:0] slots_t;

	typedef struct packed {
		logic  valid;
		logic  last;
		byte_t data;
	} cell_t;

	typedef struct packed {
		logic load;
		logic shift;
	} ctl_t;

endpackage

@@ rtl/bkrf_cell.sv @@
// one byte cell of the output shift chain
module bkrf_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  bkrf_pkg::ctl_t  ctl,
	input  bkrf_pkg::cell_t load_item,
	input  bkrf_pkg::cell_t next_item,
	output bkrf_pkg::cell_t item
);

	logic            valid_q;
	logic            last_q;
	bkrf_pkg::byte_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= load_item.valid;
		end else if (ctl.shift) begin
			valid_q <= next_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			last_q <= load_item.last;
			data_q <= load_item.data;
		end else if (ctl.shift) begin
			last_q <= next_item.last;
			data_q <= next_item.data;
		end
	end

	assign item = '{valid: valid_q, last: last_q, data: data_q};

endmodule

@@ rtl/bkrf_encode.sv @@
// key slot encoding, change detection and frame checksum
module bkrf_encode (
	input  logic [bkrf_pkg::LEVEL_COUNT-1:0] levels,
	input  bkrf_pkg::slots_t                prev_slots,
	input  bkrf_pkg::byte_t                 device_address,
	output bkrf_pkg::slots_t                slots,
	output logic                            changed,
	output bkrf_pkg::byte_t                 checksum
);

	localparam bkrf_pkg::byte_t FIXED_SUM = bkrf_pkg::byte_t'(
		bkrf_pkg::SYNC0 + bkrf_pkg::SYNC1 + bkrf_pkg::CMD_BYTE + bkrf_pkg::LEN_BYTE
		+ bkrf_pkg::PAD_BYTE + bkrf_pkg::PAD_BYTE);

	always_comb begin
		slots[0] = levels[bkrf_pkg::L_LEFT]  ? bkrf_pkg::CODE_NONE : bkrf_pkg::CODE_LEFT;
		slots[1] = levels[bkrf_pkg::L_DOWN]  ? bkrf_pkg::CODE_NONE : bkrf_pkg::CODE_DOWN;
		slots[2] = levels[bkrf_pkg::L_UP]    ? bkrf_pkg::CODE_NONE : bkrf_pkg::CODE_UP;
		slots[3] = levels[bkrf_pkg::L_RIGHT] ? bkrf_pkg::CODE_NONE : bkrf_pkg::CODE_RIGHT;
		slots[4] = levels[bkrf_pkg::L_ENTER] ? bkrf_pkg::CODE_NONE : bkrf_pkg::CODE_ENTER;
		if (!levels[bkrf_pkg::L_ESCAPE]) begin
			slots[5] = bkrf_pkg::CODE_ESCAPE;
		end else if (!levels[bkrf_pkg::L_SPACE]) begin
			slots[5] = bkrf_pkg::CODE_SPACE;
		end else begin
			slots[5] = bkrf_pkg::CODE_NONE;
		end
	end

	assign changed = (slots != prev_slots);

	assign checksum = FIXED_SUM + device_address + slots[0] + slots[1] + slots[2]
		+ slots[3] + slots[4] + slots[5];

endmodule

@@ rtl/button_keyboard_report_framer_core.sv @@
// top level of the button keyboard report framer
// Each input item is one scan of seven active-low buttons. A scan whose key
// codes differ from the previous scan produces a 14-byte report frame on the
// output stream, one byte per cycle while m_tready is high, tlast on the
// checksum byte; an unchanged scan produces nothing. The frame is loaded in
// parallel into a chain of 14 byte cells that shifts toward the output. A scan
// is taken when at most one byte of the previous frame is left and the output
// is not stalled (so the next frame follows its checksum byte without a gap);
// an unchanged scan leaves the chain empty and does not hold back the next scan.
module button_keyboard_report_framer_core (
	input  logic        clk,
	input  logic        arst_n,
	// scan in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // left, down, up, right, enter, escape, space, zero
	// frame bytes out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // frame_byte
	output logic        m_tlast,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [bkrf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	bkrf_pkg::byte_t  device_address_q;
	bkrf_pkg::slots_t prev_slots_q;
	bkrf_pkg::slots_t slots;
	bkrf_pkg::byte_t  checksum;
	logic             changed;
	logic             accept;
	bkrf_pkg::ctl_t   ctl;

	bkrf_pkg::cell_t  cell_item [bkrf_pkg::FRAME_LEN];
	bkrf_pkg::cell_t  load_item [bkrf_pkg::FRAME_LEN];
	bkrf_pkg::cell_t  next_item [bkrf_pkg::FRAME_LEN];
	bkrf_pkg::byte_t  frame     [bkrf_pkg::FRAME_LEN];

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr == bkrf_pkg::REG_DEVICE_ADDRESS) ? {24'd0, device_address_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= '0;
		end else if (psel && penable && pwrite && pready
			&& paddr == bkrf_pkg::REG_DEVICE_ADDRESS) begin
			device_address_q <= pwdata[7:0];
		end
	end

	bkrf_encode u_encode (
		.levels         (s_tdata[bkrf_pkg::LEVEL_COUNT-1:0]),
		.prev_slots     (prev_slots_q),
		.device_address (device_address_q),
		.slots          (slots),
		.changed        (changed),
		.checksum       (checksum)
	);

	assign ctl.shift = !cell_item[0].valid || m_tready;
	assign s_tready  = ctl.shift && !cell_item[1].valid;
	assign accept    = s_tvalid && s_tready;
	assign ctl.load  = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_slots_q <= '0;
		end else if (accept) begin
			prev_slots_q <= slots;
		end
	end

	always_comb begin
		frame[0] = bkrf_pkg::SYNC0;
		frame[1] = bkrf_pkg::SYNC1;
		frame[2] = device_address_q;
		frame[3] = bkrf_pkg::CMD_BYTE;
		frame[4] = bkrf_pkg::LEN_BYTE;
		frame[5] = bkrf_pkg::PAD_BYTE;
		frame[6] = bkrf_pkg::PAD_BYTE;
		for (int i = 0; i < bkrf_pkg::SLOT_COUNT; i++) begin
			frame[7+i] = slots[i];
		end
		frame[bkrf_pkg::FRAME_LEN-1] = checksum;
		for (int i = 0; i < bkrf_pkg::FRAME_LEN; i++) begin
			load_item[i].valid = changed;
			load_item[i].last  = (i == bkrf_pkg::FRAME_LEN - 1);
			load_item[i].data  = frame[i];
			next_item[i] = (i == bkrf_pkg::FRAME_LEN - 1) ? '0 : cell_item[(i+1)%bkrf_pkg::FRAME_LEN];
		end
	end

	for (genvar g = 0; g < bkrf_pkg::FRAME_LEN; g++) begin : g_cell
		bkrf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.load_item (load_item[g]),
			.next_item (next_item[g]),
			.item      (cell_item[g])
		);
	end

	assign m_tvalid = cell_item[0].valid;
	assign m_tdata  = cell_item[0].data;
	assign m_tlast  = cell_item[0].last;

	a_frame_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && changed |=> m_tvalid && m_tdata == bkrf_pkg::SYNC0)
		else $error("loaded frame does not start with sync byte");

	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !cell_item[1].valid)
		else $error("bytes queued behind checksum byte");

	a_next_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata == bkrf_pkg::SYNC0)
		else $error("frame after checksum byte does not start with sync byte");

endmodule

@@ verif/button_keyboard_report_framer_core_test.sv @@
// testbench for button_keyboard_report_framer_core: random scans, frame prediction, byte checks
module button_keyboard_report_framer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bkrf_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_CYCLES   = 300;

	typedef logic [LEVEL_COUNT-1:0] levels_t;

	typedef struct {
		byte_t data;
		logic  last;
	} frame_beat_t;

	class report_frame_board;
		byte_t       dev_addr;
		slots_t      held_keys;
		frame_beat_t frame_q[$];
		int          errors;
		int          scans;
		int          frames;
		int          bytes_seen;

		function new();
			dev_addr   = '0;
			held_keys  = '0;
			errors     = 0;
			scans      = 0;
			frames     = 0;
			bytes_seen = 0;
		endfunction

		function void set_address(byte_t a);
			dev_addr = a;
		endfunction

		function int pending();
			return frame_q.size();
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		function void note_scan(levels_t lv);
			slots_t      keys;
			byte_t       fr[FRAME_LEN];
			byte_t       sum;
			frame_beat_t b;
			keys[0] = lv[L_LEFT]  ? CODE_NONE : CODE_LEFT;
			keys[1] = lv[L_DOWN]  ? CODE_NONE : CODE_DOWN;
			keys[2] = lv[L_UP]    ? CODE_NONE : CODE_UP;
			keys[3] = lv[L_RIGHT] ? CODE_NONE : CODE_RIGHT;
			keys[4] = lv[L_ENTER] ? CODE_NONE : CODE_ENTER;
			if (!lv[L_ESCAPE])
				keys[5] = CODE_ESCAPE;
			else if (!lv[L_SPACE])
				keys[5] = CODE_SPACE;
			else
				keys[5] = CODE_NONE;
			scans++;
			if (keys == held_keys)
				return;
			held_keys = keys;
			frames++;
			fr[0] = SYNC0;
			fr[1] = SYNC1;
			fr[2] = dev_addr;
			fr[3] = CMD_BYTE;
			fr[4] = LEN_BYTE;
			fr[5] = PAD_BYTE;
			fr[6] = PAD_BYTE;
			for (int i = 0; i < SLOT_COUNT; i++)
				fr[7 + i] = keys[i];
			sum = '0;
			for (int i = 0; i < FRAME_LEN - 1; i++)
				sum += fr[i];
			fr[FRAME_LEN - 1] = sum;
			for (int i = 0; i < FRAME_LEN; i++) begin
				b.data = fr[i];
				b.last = (i == FRAME_LEN - 1);
				frame_q.push_back(b);
			end
		endfunction

		task check_byte(byte_t data, logic last);
			frame_beat_t w;
			bytes_seen++;
			if (frame_q.size() == 0) begin
				report($sformatf("byte %02h last %0b with no frame pending", data, last));
				return;
			end
			w = frame_q.pop_front();
			if (data !== w.data)
				report($sformatf("frame byte %02h, want %02h", data, w.data));
			if (last !== w.last)
				report($sformatf("tlast %0b on byte %02h, want %0b", last, data, w.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;  // left, down, up, right, enter, escape, space, zero
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // frame_byte
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	report_frame_board board = new();

	bit      tx_steady;
	bit      rx_steady;
	bit      hold_req;
	int      holds_done;
	int      addr_writes;
	levels_t last_levels;

	levels_t directed_scans[$] = '{
		7'h7F, 7'h7F, 7'h7E, 7'h7D, 7'h7B, 7'h77, 7'h6F, 7'h5F, 7'h3F,
		7'h1F, 7'h5F, 7'h3F, 7'h00, 7'h00, 7'h7F
	};

	button_keyboard_report_framer_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("** button_keyboard_report_framer_core: FAILED **");
		$finish;
	end

	function automatic int pick_gap(bit steady);
		int r;
		r = $urandom_range(0, 19);
		if (steady || r < 10)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// output side: random stalls, steady stretches and one long hold
	initial begin
		int  run_left;
		bit  run_ready;
		m_tready <= 1'b0;
		run_left = 0;
		run_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				for (int held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else begin
				if (run_left == 0) begin
					run_ready = ($urandom_range(0, 3) != 0);
					run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
						: $urandom_range(1, 4);
				end
				run_left--;
				m_tready <= rx_steady || run_ready;
				@(posedge clk);
				if (m_tvalid && m_tready)
					board.check_byte(m_tdata, m_tlast);
			end
		end
	end

	task send_scan(levels_t lv);
		int gap;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, lv};
		do
			@(posedge clk);
		while (!s_tready);
		board.note_scan(lv);
		last_levels = lv;
	endtask

	function automatic levels_t next_levels(levels_t prev);
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return levels_t'($urandom());
		if (r < 9)
			return prev;
		return prev ^ {levels_t'($urandom_range(1, 3)) << L_ESCAPE};
	endfunction

	task settle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write the address register, then read it back
	task config_address(logic [31:0] word);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_DEVICE_ADDRESS;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		board.set_address(word[7:0]);
		addr_writes++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== {24'h0, word[7:0]})
			board.report($sformatf("device_address reads %08h, want %02h", prdata, word[7:0]));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task run_phase(int count, logic [31:0] word, bit quiet_tx, bit quiet_rx, bit pressure);
		settle();
		config_address(word);
		tx_steady = quiet_tx;
		rx_steady = quiet_rx;
		if (pressure)
			hold_req = 1'b1;
		repeat (count)
			send_scan(next_levels(last_levels));
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_req = 1'b0;
		holds_done = 0;
		addr_writes = 0;
		last_levels = '1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_scans[i])
			send_scan(directed_scans[i]);

		run_phase(40, ($urandom() & 32'hFFFF_FF00) | 32'h0000_00FF, 1'b0, 1'b0, 1'b0);
		run_phase(30, $urandom() & 32'hFFFF_FF00, 1'b1, 1'b0, 1'b1);
		run_phase(30, $urandom(), 1'b1, 1'b1, 1'b0);
		run_phase(50, $urandom(), 1'b0, 1'b0, 1'b0);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d scans, %0d frames, %0d bytes checked", board.scans,
			board.frames, board.bytes_seen);
		$display("with %0d address writes and %0d long output holds, %0d mismatches",
			addr_writes, holds_done, board.errors);
		if (board.errors == 0)
			$display("** button_keyboard_report_framer_core: PASSED **");
		else
			$display("** button_keyboard_report_framer_core: FAILED **");
		$finish;
	end

endmodule

@@ button_keyboard_report_framer_core.f @@
rtl/bkrf_pkg.sv
rtl/bkrf_cell.sv
rtl/bkrf_encode.sv
rtl/button_keyboard_report_framer_core.sv
verif/button_keyboard_report_framer_core_test.sv
